[src/text_mode_cell_line_fetch_unit_defines.svh]
// Assertion macros shared by the text mode cell line fetch unit.
`ifndef TEXT_MODE_CELL_LINE_FETCH_UNIT_DEFINES_SVH
`define TEXT_MODE_CELL_LINE_FETCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the unit clock, off during reset.
`define TMCL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmcl: same-cycle check failed");

// Next-cycle implication, checked on the unit clock, off during reset.
`define TMCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmcl: next-cycle check failed");

`endif

[src/tmcl_pkg.sv]
// Types, constants and tables of the text mode cell line fetch unit.
`default_nettype none

package tmcl_pkg;

  localparam int VRAM_DEPTH      = 2048;
  localparam int GLYPH_LINES     = 16;
  localparam int MAX_COLUMNS     = 80;
  localparam int MAX_FRAME_LINES = 256;

  localparam int VRAM_AW      = $clog2(VRAM_DEPTH);
  localparam int GLYPH_LINE_W = $clog2(GLYPH_LINES);
  localparam int GLYPH_AW     = 8 + GLYPH_LINE_W;
  localparam int GLYPH_DEPTH  = 1 << GLYPH_AW;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int MADDR_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 8;
  localparam int COL_W    = 8;
  localparam int LINE_W   = 5;
  localparam int TIME_W   = 40;
  localparam int HEIGHT_W = 9;
  localparam int ADDR_W   = 11;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int LINES_W    = LINE_W + 1;
  localparam int LINE_CODES = 1 << LINE_W;
  localparam int ROWS_W     = $clog2(MAX_FRAME_LINES + 1);
  localparam int ADDR_SUM_W = 17;

  localparam logic [HEIGHT_W-1:0] EMPTY_HEIGHT = HEIGHT_W'(225);
  localparam logic [BYTE_W-1:0]   CURSOR_BYTE  = 8'hff;

  // reset values of the registers
  localparam logic [COL_W-1:0]  RST_COLUMNS    = COL_W'(80);
  localparam logic [ROW_W-1:0]  RST_ROWS       = ROW_W'(25);
  localparam logic [LINE_W-1:0] RST_MAX_SCAN   = LINE_W'(8);
  localparam logic [LINE_W-1:0] RST_CURSOR_END = LINE_W'(31);

  // blink: floor(t / half) = floor((t >> shift) / BLINK_BASE)
  localparam int FAST_HALF_PERIOD = 1000000;
  localparam int BLINK_SHIFT      = 6;
  localparam int BLINK_BASE       = FAST_HALF_PERIOD / (1 << BLINK_SHIFT);
  localparam int BLINK_MOD        = 2 * BLINK_BASE;
  localparam int REM_W            = $clog2(BLINK_MOD);
  localparam int DIV_BITS         = 4;
  localparam int DIV_STEPS        = (TIME_W - BLINK_SHIFT + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_X_W          = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_VRAM_WR  = 2'd0,
    FUNC_GLYPH_WR = 2'd1,
    FUNC_FETCH    = 2'd2
  } tmcl_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS      = 3'd0,
    CFG_ROWS         = 3'd1,
    CFG_MAX_SCAN     = 3'd2,
    CFG_START_ADDR   = 3'd3,
    CFG_CURSOR_ADDR  = 3'd4,
    CFG_CURSOR_MODE  = 3'd5,
    CFG_CURSOR_FIRST = 3'd6,
    CFG_CURSOR_LAST  = 3'd7
  } tmcl_cfg_e;

  typedef enum logic [MODE_W-1:0] {
    CURSOR_STEADY = 2'd0,
    CURSOR_OFF    = 2'd1,
    CURSOR_FAST   = 2'd2,
    CURSOR_SLOW   = 2'd3
  } tmcl_cursor_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_VRAM,
    S_BLINK,
    S_GLYPH,
    S_OUT
  } tmcl_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [MADDR_W-1:0] mem_address;
    logic [BYTE_W-1:0]  mem_data;
    logic [ROW_W-1:0]   text_row;
    logic [COL_W-1:0]   text_column;
    logic [LINE_W-1:0]  scan_line;
    logic [TIME_W-1:0]  time_count;
  } tmcl_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   pixel_bits;
    logic                cell_visible;
    logic [HEIGHT_W-1:0] frame_height;
  } tmcl_out_t;

  typedef struct packed {
    logic done;
    logic odd;
  } tmcl_div_stat_t;

  // rows that fit the frame, indexed by lines minus one
  typedef logic [LINE_CODES-1:0][ROWS_W-1:0] tmcl_rows_tab_t;

  function automatic tmcl_rows_tab_t build_rows_fit();
    tmcl_rows_tab_t tab;
    int l;
    int r;
    tab = '0;
    for (l = 0; l < LINE_CODES; l++) begin
      for (r = 0; r <= MAX_FRAME_LINES; r++) begin
        if (r * (l + 1) <= MAX_FRAME_LINES) tab[l] = ROWS_W'(r);
      end
    end
    return tab;
  endfunction

  localparam tmcl_rows_tab_t ROWS_FIT = build_rows_fit();

endpackage

`default_nettype wire

[src/tmcl_blink_div.sv]
// Iterative remainder unit: parity of a dividend over the blink base period.
`default_nettype none

module tmcl_blink_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tmcl_pkg::DIV_X_W-1:0] dividend_i,
  output tmcl_pkg::tmcl_div_stat_t          stat_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tmcl_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [tmcl_pkg::DIV_X_W-1:0]   x_q, x_d;
  logic [tmcl_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [tmcl_pkg::REM_W-1:0]     rem_step;

  // DIV_BITS dividend bits per cycle, remainder kept below BLINK_MOD
  always_comb begin
    logic [tmcl_pkg::REM_W:0] r;
    r = {1'b0, rem_q};
    for (int k = 0; k < tmcl_pkg::DIV_BITS; k++) begin
      r = {r[tmcl_pkg::REM_W-1:0], x_q[tmcl_pkg::DIV_X_W-1-k]};
      if (r >= (tmcl_pkg::REM_W + 1)'(tmcl_pkg::BLINK_MOD)) begin
        r = r - (tmcl_pkg::REM_W + 1)'(tmcl_pkg::BLINK_MOD);
      end
    end
    rem_step = r[tmcl_pkg::REM_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      x_d   = x_q << tmcl_pkg::DIV_BITS;
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tmcl_pkg::DIV_CNT_W'(tmcl_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
  end

  // quotient is odd when the remainder mod twice the base reaches the base
  assign stat_o.done = done_q;
  assign stat_o.odd  = (rem_q >= tmcl_pkg::REM_W'(tmcl_pkg::BLINK_BASE));

endmodule

`default_nettype wire

[src/text_mode_cell_line_fetch_unit.sv]
// Text mode character generator: video RAM, glyph RAM, cursor and cell fetch.
//
// Input channel (in_valid_i / in_stall_o / in_i) carries one request per item:
// a video RAM write, a glyph write, or a fetch of one eight-pixel cell line.
// Writes give no result; unused function codes are dropped.
// A fetch walks calc, video RAM read, glyph read and output load; the next
// request is taken once its result is loaded into the output register.
// With a blinking cursor the blink phase is found between the video RAM read
// and the glyph read by a 4-bit-per-cycle remainder unit.
// The memory read ports are registered.
// Output channel (out_valid_o / out_stall_i / out_o) is one register deep; a new
// request is taken while a result waits, and a fetch that finishes while the
// register is full and stalled holds in its last step until the slot frees.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once;
// change them only while no fetch is in flight.
// After reset the video RAM is cleared one entry a cycle, all 2048 entries, during
// which in_stall_o stays high. Glyph memory is not cleared; load it before use.
`default_nettype none

module text_mode_cell_line_fetch_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire tmcl_pkg::tmcl_in_t              in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output tmcl_pkg::tmcl_out_t                  out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tmcl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tmcl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

`include "text_mode_cell_line_fetch_unit_defines.svh"

  // configuration registers
  logic [tmcl_pkg::COL_W-1:0]  columns_q;
  logic [tmcl_pkg::ROW_W-1:0]  rows_q;
  logic [tmcl_pkg::LINE_W-1:0] max_scan_q;
  logic [tmcl_pkg::ADDR_W-1:0] start_addr_q;
  logic [tmcl_pkg::ADDR_W-1:0] cursor_addr_q;
  logic [tmcl_pkg::MODE_W-1:0] cursor_mode_q;
  logic [tmcl_pkg::LINE_W-1:0] cursor_first_q;
  logic [tmcl_pkg::LINE_W-1:0] cursor_last_q;

  tmcl_pkg::tmcl_state_e       state_q, state_d;
  logic [tmcl_pkg::VRAM_AW-1:0] clr_q, clr_d;
  logic                        out_valid_q, out_valid_d;
  tmcl_pkg::tmcl_out_t         out_q;

  // fetch payload
  logic [tmcl_pkg::ROW_W-1:0]    row_q;
  logic [tmcl_pkg::COL_W-1:0]    col_q;
  logic [tmcl_pkg::LINE_W-1:0]   line_q;
  logic [tmcl_pkg::TIME_W-1:0]   time_q;
  logic [tmcl_pkg::COL_W-1:0]    cols_q;
  logic [tmcl_pkg::LINES_W-1:0]  lines_q;
  logic [tmcl_pkg::ROWS_W-1:0]   rows_eff_q;
  logic [tmcl_pkg::VRAM_AW-1:0]  addr_q;
  logic                          visible_q;
  logic [tmcl_pkg::HEIGHT_W-1:0] height_q;
  logic                          hit_q;
  logic                          cur_on_q, cur_on_d;

  // memories
  logic [tmcl_pkg::BYTE_W-1:0] vram_mem [tmcl_pkg::VRAM_DEPTH];
  logic [tmcl_pkg::BYTE_W-1:0] glyph_mem [tmcl_pkg::GLYPH_DEPTH];
  logic [tmcl_pkg::BYTE_W-1:0] vram_rd_q;
  logic [tmcl_pkg::BYTE_W-1:0] glyph_rd_q;
  logic                        vram_we, glyph_we, vram_re, glyph_re;
  logic [tmcl_pkg::VRAM_AW-1:0]  vram_waddr;
  logic [tmcl_pkg::BYTE_W-1:0]   vram_wdata;
  logic [tmcl_pkg::GLYPH_AW-1:0] glyph_raddr;

  logic in_acc;
  logic load_out;
  logic out_blocked;
  logic div_start;
  logic blink_mode;
  logic [tmcl_pkg::DIV_X_W-1:0] dividend;
  tmcl_pkg::tmcl_div_stat_t     div_stat;

  // calc and video RAM step values
  logic [tmcl_pkg::LINES_W-1:0]    lines_c;
  logic [tmcl_pkg::COL_W-1:0]      cols_c;
  logic [13:0]                     rows_lines_c;
  logic [tmcl_pkg::ROWS_W-1:0]     rows_eff_c;
  logic [tmcl_pkg::ADDR_SUM_W-1:0] addr_sum_c;
  logic [14:0]                     height_prod_c;
  logic [tmcl_pkg::HEIGHT_W-1:0]   height_c;
  logic                            visible_c;
  logic                            hit_c;

  assign in_stall_o = (state_q != tmcl_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign blink_mode = (cursor_mode_q == tmcl_pkg::CURSOR_FAST) ||
                      (cursor_mode_q == tmcl_pkg::CURSOR_SLOW);

  assign lines_c      = tmcl_pkg::LINES_W'(max_scan_q) + 1'b1;
  assign cols_c       = (columns_q > tmcl_pkg::COL_W'(tmcl_pkg::MAX_COLUMNS)) ?
                        tmcl_pkg::COL_W'(tmcl_pkg::MAX_COLUMNS) : columns_q;
  assign rows_lines_c = 14'(rows_q) * 14'(lines_c);
  assign rows_eff_c   = (rows_lines_c > 14'(tmcl_pkg::MAX_FRAME_LINES)) ?
                        tmcl_pkg::ROWS_FIT[max_scan_q] : tmcl_pkg::ROWS_W'(rows_q);
  assign addr_sum_c   = tmcl_pkg::ADDR_SUM_W'(start_addr_q)
                      + tmcl_pkg::ADDR_SUM_W'(16'(row_q) * 16'(cols_c))
                      + tmcl_pkg::ADDR_SUM_W'(col_q);

  assign height_prod_c = 15'(rows_eff_q) * 15'(lines_q);
  assign height_c      = (height_prod_c == '0) ? tmcl_pkg::EMPTY_HEIGHT :
                         tmcl_pkg::HEIGHT_W'(height_prod_c);
  assign visible_c     = (tmcl_pkg::ROWS_W'(row_q) < rows_eff_q) && (col_q < cols_q) &&
                         (tmcl_pkg::LINES_W'(line_q) < lines_q);
  assign hit_c         = (addr_q == tmcl_pkg::VRAM_AW'(cursor_addr_q)) &&
                         (line_q >= cursor_first_q) && (line_q <= cursor_last_q);

  // slow blink has twice the half period: one more bit of shift
  assign dividend = (cursor_mode_q == tmcl_pkg::CURSOR_SLOW) ?
                    tmcl_pkg::DIV_X_W'(time_q >> (tmcl_pkg::BLINK_SHIFT + 1)) :
                    tmcl_pkg::DIV_X_W'(time_q >> tmcl_pkg::BLINK_SHIFT);

  assign glyph_raddr = {vram_rd_q, line_q[tmcl_pkg::GLYPH_LINE_W-1:0]};

  tmcl_blink_div u_blink_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    vram_we    = 1'b0;
    glyph_we   = 1'b0;
    vram_re    = 1'b0;
    glyph_re   = 1'b0;
    vram_waddr = tmcl_pkg::VRAM_AW'(in_i.mem_address);
    vram_wdata = in_i.mem_data;
    div_start  = 1'b0;
    load_out   = 1'b0;
    cur_on_d   = cur_on_q;
    case (state_q)
      tmcl_pkg::S_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr_q;
        vram_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == '1) state_d = tmcl_pkg::S_IDLE;
      end
      tmcl_pkg::S_IDLE: begin
        if (in_acc) begin
          case (tmcl_pkg::tmcl_func_e'(in_i.func))
            tmcl_pkg::FUNC_VRAM_WR:  vram_we  = 1'b1;
            tmcl_pkg::FUNC_GLYPH_WR: glyph_we = 1'b1;
            tmcl_pkg::FUNC_FETCH:    state_d  = tmcl_pkg::S_CALC;
            default: ;
          endcase
        end
      end
      tmcl_pkg::S_CALC: begin
        state_d = tmcl_pkg::S_VRAM;
      end
      tmcl_pkg::S_VRAM: begin
        vram_re  = 1'b1;
        cur_on_d = (cursor_mode_q == tmcl_pkg::CURSOR_STEADY);
        if (blink_mode) begin
          div_start = 1'b1;
          state_d   = tmcl_pkg::S_BLINK;
        end else begin
          state_d = tmcl_pkg::S_GLYPH;
        end
      end
      tmcl_pkg::S_BLINK: begin
        if (div_stat.done) begin
          cur_on_d = !div_stat.odd;
          state_d  = tmcl_pkg::S_GLYPH;
        end
      end
      tmcl_pkg::S_GLYPH: begin
        glyph_re = 1'b1;
        state_d  = tmcl_pkg::S_OUT;
      end
      tmcl_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = tmcl_pkg::S_IDLE;
        end
      end
      default: state_d = tmcl_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign out_blocked = (state_q == tmcl_pkg::S_OUT) && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tmcl_pkg::S_CLEAR;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      columns_q      <= tmcl_pkg::RST_COLUMNS;
      rows_q         <= tmcl_pkg::RST_ROWS;
      max_scan_q     <= tmcl_pkg::RST_MAX_SCAN;
      start_addr_q   <= '0;
      cursor_addr_q  <= '0;
      cursor_mode_q  <= tmcl_pkg::CURSOR_STEADY;
      cursor_first_q <= '0;
      cursor_last_q  <= tmcl_pkg::RST_CURSOR_END;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (tmcl_pkg::tmcl_cfg_e'(cfg_index_i))
          tmcl_pkg::CFG_COLUMNS:      columns_q      <= cfg_data_i[tmcl_pkg::COL_W-1:0];
          tmcl_pkg::CFG_ROWS:         rows_q         <= cfg_data_i[tmcl_pkg::ROW_W-1:0];
          tmcl_pkg::CFG_MAX_SCAN:     max_scan_q     <= cfg_data_i[tmcl_pkg::LINE_W-1:0];
          tmcl_pkg::CFG_START_ADDR:   start_addr_q   <= cfg_data_i[tmcl_pkg::ADDR_W-1:0];
          tmcl_pkg::CFG_CURSOR_ADDR:  cursor_addr_q  <= cfg_data_i[tmcl_pkg::ADDR_W-1:0];
          tmcl_pkg::CFG_CURSOR_MODE:  cursor_mode_q  <= cfg_data_i[tmcl_pkg::MODE_W-1:0];
          tmcl_pkg::CFG_CURSOR_FIRST: cursor_first_q <= cfg_data_i[tmcl_pkg::LINE_W-1:0];
          tmcl_pkg::CFG_CURSOR_LAST:  cursor_last_q  <= cfg_data_i[tmcl_pkg::LINE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_on_q <= cur_on_d;
    if (in_acc) begin
      row_q  <= in_i.text_row;
      col_q  <= in_i.text_column;
      line_q <= in_i.scan_line;
      time_q <= in_i.time_count;
    end
    if (state_q == tmcl_pkg::S_CALC) begin
      cols_q     <= cols_c;
      lines_q    <= lines_c;
      rows_eff_q <= rows_eff_c;
      addr_q     <= tmcl_pkg::VRAM_AW'(addr_sum_c);
    end
    if (state_q == tmcl_pkg::S_VRAM) begin
      visible_q <= visible_c;
      height_q  <= height_c;
      hit_q     <= hit_c;
    end
    if (load_out) begin
      out_q.cell_visible <= visible_q;
      out_q.frame_height <= height_q;
      if (!visible_q) begin
        out_q.pixel_bits <= '0;
      end else if (hit_q && cur_on_q) begin
        out_q.pixel_bits <= tmcl_pkg::CURSOR_BYTE;
      end else begin
        out_q.pixel_bits <= glyph_rd_q;
      end
    end
  end

  // video RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (vram_we) vram_mem[vram_waddr] <= vram_wdata;
    if (vram_re) vram_rd_q <= vram_mem[addr_q];
  end

  // glyph RAM
  always_ff @(posedge clk_i) begin
    if (glyph_we) glyph_mem[tmcl_pkg::GLYPH_AW'(in_i.mem_address)] <= in_i.mem_data;
    if (glyph_re) glyph_rd_q <= glyph_mem[glyph_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TMCL_ASSERT_SAME(a_no_result_in_clear, state_q == tmcl_pkg::S_CLEAR, !out_valid_q)
  `TMCL_ASSERT_SAME(a_div_done_in_blink, div_stat.done, state_q == tmcl_pkg::S_BLINK)
  `TMCL_ASSERT_NEXT(a_out_waits_for_slot, out_blocked, state_q == tmcl_pkg::S_OUT)
  `TMCL_ASSERT_SAME(a_hidden_cell_dark, out_valid_o && !out_o.cell_visible, out_o.pixel_bits == '0)

endmodule

`default_nettype wire

[verif/tmcl_checker.sv]
// Result checker of the text mode cell line fetch unit: shadow memories, prediction, compare.
module tmcl_checker
  import tmcl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  tmcl_in_t                   in_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  tmcl_out_t                  out_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         checked_o
);

  logic [BYTE_W-1:0] vram_copy  [VRAM_DEPTH];
  logic [BYTE_W-1:0] glyph_copy [GLYPH_DEPTH];

  logic [COL_W-1:0]  cols_r;
  logic [ROW_W-1:0]  rows_r;
  logic [LINE_W-1:0] max_scan_r;
  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] cursor_r;
  tmcl_cursor_e      mode_r;
  logic [LINE_W-1:0] first_r;
  logic [LINE_W-1:0] last_r;

  tmcl_out_t line_q [$];
  tmcl_out_t want;
  int        mismatches = 0;
  int        compared   = 0;
  int        pending    = 0;

  assign errors_o  = mismatches;
  assign pending_o = pending;
  assign checked_o = compared;

  // Expected eight-pixel slice for one fetch request under the current registers.
  function automatic tmcl_out_t fetch_cell_line(tmcl_in_t req);
    tmcl_out_t       res;
    int              columns;
    int              rows;
    int              lines;
    int              height;
    int              addr;
    int              gidx;
    longint unsigned t;
    longint unsigned half;
    bit              cur_shown;
    res     = '0;
    columns = (cols_r > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_r);
    rows    = int'(rows_r);
    lines   = int'(max_scan_r) + 1;
    if (rows * lines > MAX_FRAME_LINES) rows = MAX_FRAME_LINES / lines;
    height = rows * lines;
    if (height == 0) height = int'(EMPTY_HEIGHT);

    cur_shown = (mode_r != CURSOR_OFF);
    if (mode_r == CURSOR_FAST || mode_r == CURSOR_SLOW) begin
      t    = req.time_count;
      half = (mode_r == CURSOR_FAST) ? longint'(FAST_HALF_PERIOD) :
                                       longint'(2 * FAST_HALF_PERIOD);
      cur_shown = ((t / half) & 1) == 0;
    end

    if (int'(req.text_row) < rows && int'(req.text_column) < columns &&
        int'(req.scan_line) < lines) begin
      addr = (int'(start_r) + int'(req.text_row) * columns + int'(req.text_column))
             & (VRAM_DEPTH - 1);
      gidx = (int'(vram_copy[addr]) * GLYPH_LINES + int'(req.scan_line) % GLYPH_LINES)
             % GLYPH_DEPTH;
      res.pixel_bits = glyph_copy[gidx];
      if (cur_shown && addr == int'(cursor_r) &&
          req.scan_line >= first_r && req.scan_line <= last_r)
        res.pixel_bits = CURSOR_BYTE;
      res.cell_visible = 1'b1;
    end
    res.frame_height = HEIGHT_W'(height);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VRAM_DEPTH; i++) vram_copy[i] = '0;
      cols_r     = RST_COLUMNS;
      rows_r     = RST_ROWS;
      max_scan_r = RST_MAX_SCAN;
      start_r    = '0;
      cursor_r   = '0;
      mode_r     = CURSOR_STEADY;
      first_r    = '0;
      last_r     = RST_CURSOR_END;
      line_q.delete();
      pending    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMNS:      cols_r     = cfg_data_i[COL_W-1:0];
          CFG_ROWS:         rows_r     = cfg_data_i[ROW_W-1:0];
          CFG_MAX_SCAN:     max_scan_r = cfg_data_i[LINE_W-1:0];
          CFG_START_ADDR:   start_r    = cfg_data_i[ADDR_W-1:0];
          CFG_CURSOR_ADDR:  cursor_r   = cfg_data_i[ADDR_W-1:0];
          CFG_CURSOR_MODE:  mode_r     = tmcl_cursor_e'(cfg_data_i[MODE_W-1:0]);
          CFG_CURSOR_FIRST: first_r    = cfg_data_i[LINE_W-1:0];
          CFG_CURSOR_LAST:  last_r     = cfg_data_i[LINE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (line_q.size() == 0) begin
          mismatches++;
          $error("result with no fetch pending: pixel_bits %02h visible %0d height %0d",
                 out_i.pixel_bits, out_i.cell_visible, out_i.frame_height);
        end else begin
          want = line_q.pop_front();
          compared++;
          if (out_i.pixel_bits !== want.pixel_bits) begin
            mismatches++;
            $error("pixel_bits: expected %02h, got %02h", want.pixel_bits, out_i.pixel_bits);
          end
          if (out_i.cell_visible !== want.cell_visible) begin
            mismatches++;
            $error("cell_visible: expected %0d, got %0d", want.cell_visible, out_i.cell_visible);
          end
          if (out_i.frame_height !== want.frame_height) begin
            mismatches++;
            $error("frame_height: expected %0d, got %0d", want.frame_height, out_i.frame_height);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_i.func)
          FUNC_VRAM_WR:  vram_copy[in_i.mem_address[VRAM_AW-1:0]]   = in_i.mem_data;
          FUNC_GLYPH_WR: glyph_copy[in_i.mem_address[GLYPH_AW-1:0]] = in_i.mem_data;
          FUNC_FETCH:    line_q.push_back(fetch_cell_line(in_i));
          default: ;  // unused code, dropped
        endcase
      end
      pending = line_q.size();
    end
  end

endmodule

[verif/tb.sv]
// Testbench top of the text mode cell line fetch unit: stimulus, watchdog and verdict.
module tb;
  import tmcl_pkg::*;

  localparam int IDLE_LIMIT      = 8000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 300;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // characters that random video RAM writes may hold, each with a loaded glyph
  localparam int LOADED_CHARS    = 16;
  localparam int CHAR_A          = 8'h41;
  localparam int CHAR_FULL       = 8'hff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  tmcl_in_t              in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  tmcl_out_t             out_res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int errors;
  int pending;
  int checked;
  int sent        = 0;
  int settings    = 0;
  int idle_cycles = 0;
  int rx_done     = 0;
  int quiet_tx    = 0;
  int quiet_rx    = 0;

  // raw register values as written, used only to aim requests at the display area
  int cur_cols   = 80;
  int cur_rows   = 25;
  int cur_scan   = 8;
  int cur_start  = 0;
  int cur_cursor = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  text_mode_cell_line_fetch_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tmcl_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall before each result, quiet stretches, two long holds.
  initial begin
    int gap;
    forever begin
      if (rx_done == 150 || rx_done == 700) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (quiet_rx > 0) begin
        gap = 0;
        quiet_rx--;
      end else begin
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 40) == 0) quiet_rx = $urandom_range(10, 80);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      rx_done++;
    end
  end

  task automatic send(input tmcl_in_t req);
    int gap;
    if (quiet_tx > 0) begin
      gap = 0;
      quiet_tx--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 40) == 0) quiet_tx = $urandom_range(10, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  // Stop offering, let every fetch result drain, then give the pipe time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input tmcl_cfg_e idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int cols, input int rows, input int scan, input int start,
                               input int cursor, input tmcl_cursor_e mode,
                               input int first, input int last);
    set_reg(CFG_COLUMNS, cols);
    set_reg(CFG_ROWS, rows);
    set_reg(CFG_MAX_SCAN, scan);
    set_reg(CFG_START_ADDR, start);
    set_reg(CFG_CURSOR_ADDR, cursor);
    set_reg(CFG_CURSOR_MODE, mode);
    set_reg(CFG_CURSOR_FIRST, first);
    set_reg(CFG_CURSOR_LAST, last);
    cur_cols   = cols;
    cur_rows   = rows;
    cur_scan   = scan;
    cur_start  = start;
    cur_cursor = cursor;
    settings++;
  endtask

  function automatic int pick_extreme(input int hi);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 0;
    if (sel == 1) return hi;
    return $urandom_range(0, hi);
  endfunction

  function automatic tmcl_in_t req_of(input logic [FUNC_W-1:0] func, input int addr,
                                      input int data, input int row, input int col,
                                      input int line, input longint unsigned t);
    tmcl_in_t r;
    r.func        = func;
    r.mem_address = MADDR_W'(addr);
    r.mem_data    = BYTE_W'(data);
    r.text_row    = ROW_W'(row);
    r.text_column = COL_W'(col);
    r.scan_line   = LINE_W'(line);
    r.time_count  = TIME_W'(t);
    return r;
  endfunction

  function automatic longint unsigned random_time();
    if ($urandom_range(0, 1) == 0) return TIME_W'({$urandom, $urandom});
    // straddle a blink half-period boundary
    return longint'($urandom_range(1, 1099511)) * 1000000 - 1 + $urandom_range(0, 1);
  endfunction

  function automatic tmcl_in_t random_request();
    tmcl_in_t r;
    int       pick;
    int       rows_fit;
    int       cols_fit;
    int       off;
    r = req_of(FUNC_FETCH, $urandom, $urandom, $urandom, $urandom, $urandom, random_time());
    rows_fit = MAX_FRAME_LINES / (cur_scan + 1);
    if (cur_rows < rows_fit) rows_fit = cur_rows;
    cols_fit = (cur_cols > MAX_COLUMNS) ? MAX_COLUMNS : cur_cols;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.func     = FUNC_VRAM_WR;
      r.mem_data = BYTE_W'($urandom_range(0, LOADED_CHARS - 1));
      if ($urandom_range(0, 1) == 0)
        r.mem_address[ADDR_W-1:0] = ADDR_W'(cur_start + $urandom_range(0, 255));
    end else if (pick < 16) begin
      r.func = FUNC_GLYPH_WR;
    end else if (pick < 19) begin
      r.func = FUNC_UNUSED;
    end else if (pick < 34 && cols_fit > 0) begin
      // land on the cursor cell
      off = (cur_cursor - cur_start) & (VRAM_DEPTH - 1);
      r.text_row    = ROW_W'(off / cols_fit);
      r.text_column = COL_W'(off % cols_fit);
    end else if (pick < 90) begin
      r.text_row    = ROW_W'($urandom_range(0, rows_fit));
      r.text_column = COL_W'($urandom_range(0, cols_fit));
      r.scan_line   = LINE_W'($urandom_range(0, (cur_scan + 1 > 31) ? 31 : cur_scan + 1));
    end
    return r;
  endfunction

  initial begin
    int p;
    int n;
    longint unsigned t_max;
    t_max = {TIME_W{1'b1}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // glyph memory has no reset value: load every character video RAM can hold
    for (n = 0; n < LOADED_CHARS * GLYPH_LINES; n++)
      send(req_of(FUNC_GLYPH_WR, n, $urandom, $urandom, $urandom, $urandom, random_time()));
    for (n = 0; n < GLYPH_LINES; n++) begin
      send(req_of(FUNC_GLYPH_WR, CHAR_A * GLYPH_LINES + n, $urandom, 0, 0, 0, 0));
      send(req_of(FUNC_GLYPH_WR, CHAR_FULL * GLYPH_LINES + n, $urandom, 0, 0, 0, 0));
    end

    // directed requests at reset register values
    send(req_of(FUNC_VRAM_WR, 0, CHAR_A, 0, 0, 0, 0));
    send(req_of(FUNC_VRAM_WR, 12'hfff, CHAR_FULL, 255, 255, 31, t_max));
    send(req_of(FUNC_VRAM_WR, 80, CHAR_FULL, 0, 0, 0, 0));
    send(req_of(FUNC_GLYPH_WR, 12'hff7, 8'h5a, 0, 0, 0, 0));
    send(req_of(FUNC_FETCH, 0, 0, 0, 0, 0, 0));
    send(req_of(FUNC_FETCH, 0, 0, 0, 1, 0, 0));
    send(req_of(FUNC_FETCH, 0, 0, 1, 0, 7, 0));
    send(req_of(FUNC_FETCH, 0, 0, 24, 79, 8, 0));
    send(req_of(FUNC_FETCH, 0, 0, 25, 0, 0, 0));
    send(req_of(FUNC_FETCH, 0, 0, 0, 80, 0, 0));
    send(req_of(FUNC_FETCH, 0, 0, 0, 0, 9, 0));
    send(req_of(FUNC_FETCH, 12'hfff, 8'hff, 255, 255, 31, t_max));
    send(req_of(FUNC_UNUSED, 12'hfff, 8'hff, 255, 255, 31, t_max));
    send(req_of(FUNC_FETCH, 12'hfff, 8'hff, 0, 0, 8, t_max));
    send(req_of(FUNC_FETCH, 0, 0, 0, 2, 3, 0));

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: apply_setting(255, 255, 0, 2047, 2047, CURSOR_FAST, 0, 31);
        1: apply_setting(0, 0, 31, 0, 0, CURSOR_SLOW, 31, 0);
        2: apply_setting(80, 8, 31, 1000, 1003, CURSOR_STEADY, 4, 20);
        3: apply_setting(1, 255, 15, 2040, 5, CURSOR_OFF, 0, 31);
        default: apply_setting(pick_extreme(255), pick_extreme(255), pick_extreme(31),
                               pick_extreme(2047), pick_extreme(2047),
                               tmcl_cursor_e'($urandom_range(0, 3)),
                               pick_extreme(31), pick_extreme(31));
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send(random_request());
    end

    settle();
    $display("Checked %0d fetch results of %0d accepted requests under %0d settings,",
             checked, sent, settings);
    $display("with glyphs loaded for every character in use, two long output holds");
    $display("and random gaps on both sides.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[text_mode_cell_line_fetch_unit.f]
+incdir+src
src/tmcl_pkg.sv
src/tmcl_blink_div.sv
src/text_mode_cell_line_fetch_unit.sv
verif/tmcl_checker.sv
verif/tb.sv
